>>> sv/plts_pkg.sv
package plts_pkg;

  // Default sizing of the scheduler.
  localparam int STACK_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF     = 8;

  // Width of a minute value (start, duration, remaining time).
  localparam int MIN_W = 11;

  // Source of the id for a reported task.
  typedef enum logic [1:0] {
    SRC_RUN,
    SRC_TOP,
    SRC_IN
  } emit_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch_in;
    logic      emit;
    emit_src_t emit_src;
    logic      emit_ovf;
    logic      finish;
    logic      push;
    logic      pop;
    logic      trim;
    logic      store_gap;
    logic      load_run;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_valid;
    logic ended;
    logic full;
    logic empty;
    logic gap_zero;
    logic top_fits;
    logic emit_ok;
    logic out_free;
    logic pend_valid;
    logic last;
  } dp_sts_t;

endpackage

>>> sv/plts_task_if.sv
interface plts_task_if #(
  parameter int ID_BITS = plts_pkg::ID_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic [ID_BITS-1:0]         task_id;
  logic [plts_pkg::MIN_W-1:0] start_minute;
  logic [plts_pkg::MIN_W-1:0] duration;
  logic                       last_task;

  modport source (output valid, task_id, start_minute, duration, last_task, input ready);
  modport sink   (input valid, task_id, start_minute, duration, last_task, output ready);
endinterface

>>> sv/plts_done_if.sv
interface plts_done_if #(
  parameter int ID_BITS = plts_pkg::ID_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] done_id;
  logic               overflow;
  logic               last_of_run;

  modport source (output valid, done_id, overflow, last_of_run, input ready);
  modport sink   (input valid, done_id, overflow, last_of_run, output ready);
endinterface

>>> sv/plts_datapath.sv
module plts_datapath #(
  parameter int STACK_DEPTH = plts_pkg::STACK_DEPTH_DEF,
  parameter int ID_BITS     = plts_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  plts_pkg::dp_cmd_t          cmd,
  output plts_pkg::dp_sts_t          sts,
  input  logic [ID_BITS-1:0]         in_id,
  input  logic [plts_pkg::MIN_W-1:0] in_start,
  input  logic [plts_pkg::MIN_W-1:0] in_dur,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ID_BITS-1:0]         out_id,
  output logic                       out_ovf,
  output logic                       out_last
);

  localparam int W     = plts_pkg::MIN_W;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [W-1:0]       rem;
  } entry_t;

  // Latched input word.
  logic [ID_BITS-1:0] in_id_r;
  logic [W-1:0]       in_start_r;
  logic [W-1:0]       in_dur_r;
  logic               in_last_r;

  // Running task.
  logic               run_valid_r;
  logic [ID_BITS-1:0] run_id_r;
  logic [W-1:0]       run_start_r;
  logic [W-1:0]       run_len_r;

  // Idle time left for stacked tasks, and the stack itself.
  logic [W-1:0]       gap_r;
  logic [CNT_W-1:0]   count_r;
  entry_t             mem [STACK_DEPTH];
  entry_t             rd_r;

  // One pending result, held until it is known whether another follows.
  logic               pend_valid_r;
  logic [ID_BITS-1:0] pend_id_r;
  logic               pend_ovf_r;

  // Output register.
  logic               out_valid_r;
  logic [ID_BITS-1:0] out_id_r;
  logic               out_ovf_r;
  logic               out_last_r;

  logic [W:0]         run_end;
  logic               ended;
  logic [W-1:0]       gap_new;
  logic [W-1:0]       elapsed;
  logic [W-1:0]       rem_new;
  logic               top_fits;
  logic [W-1:0]       top_left;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en;
  entry_t             wr_data;
  logic [ID_BITS-1:0] emit_id;
  logic               out_free;
  logic               emit_ok;
  logic               out_load;
  logic               full;

  // Timing of the running task against the new start.
  assign run_end  = {1'b0, run_start_r} + {1'b0, run_len_r};
  assign ended    = (run_end <= {1'b0, in_start_r});
  assign gap_new  = in_start_r - run_end[W-1:0];
  assign elapsed  = (in_start_r > run_start_r) ? (in_start_r - run_start_r) : '0;
  assign rem_new  = run_len_r - elapsed;

  // Top of stack against the idle time.
  assign top_fits = (rd_r.rem <= gap_r);
  assign top_left = rd_r.rem - gap_r;

  // Stack addressing: the read port looks at the next top on a pop and at the current top otherwise.
  assign cnt_m1  = count_r - CNT_W'(1);
  assign cnt_m2  = count_r - CNT_W'(2);
  assign rd_idx  = cmd.pop ? cnt_m2[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign wr_en   = cmd.push | cmd.trim;
  assign wr_idx  = cmd.push ? count_r[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign wr_data = cmd.push ? entry_t'{id: run_id_r, rem: rem_new}
                            : entry_t'{id: rd_r.id, rem: top_left};
  assign full    = (count_r == CNT_W'(STACK_DEPTH));

  // Id of a task being reported.
  always_comb begin
    case (cmd.emit_src)
      plts_pkg::SRC_RUN: emit_id = run_id_r;
      plts_pkg::SRC_TOP: emit_id = rd_r.id;
      plts_pkg::SRC_IN:  emit_id = in_id_r;
      default:           emit_id = run_id_r;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit_ok  = !pend_valid_r || out_free;
  assign out_load = (cmd.emit || cmd.finish) && pend_valid_r;

  // Stack memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_r <= mem[rd_idx];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      run_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.push) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop) begin
        count_r <= cnt_m1;
      end
      if (cmd.load_run) begin
        run_valid_r <= ~in_last_r;
      end
      if (cmd.emit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_id_r    <= in_id;
      in_start_r <= in_start;
      in_dur_r   <= in_dur;
      in_last_r  <= in_last;
    end
    if (cmd.load_run) begin
      run_id_r    <= in_id_r;
      run_start_r <= in_start_r;
      run_len_r   <= in_dur_r;
    end
    if (cmd.store_gap) begin
      gap_r <= gap_new;
    end else if (cmd.pop) begin
      gap_r <= gap_r - rd_r.rem;
    end
    if (cmd.emit) begin
      pend_id_r  <= emit_id;
      pend_ovf_r <= cmd.emit_ovf;
    end
    if (out_load) begin
      out_id_r   <= pend_id_r;
      out_ovf_r  <= pend_ovf_r;
      out_last_r <= cmd.finish;
    end
  end

  // Status to the controller.
  assign sts.run_valid  = run_valid_r;
  assign sts.ended      = ended;
  assign sts.full       = full;
  assign sts.empty      = (count_r == '0);
  assign sts.gap_zero   = (gap_r == '0);
  assign sts.top_fits   = top_fits;
  assign sts.emit_ok    = emit_ok;
  assign sts.out_free   = out_free;
  assign sts.pend_valid = pend_valid_r;
  assign sts.last       = in_last_r;

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

  // The stack never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  // A pop only takes place on a nonempty stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop on empty stack");

  // A push only takes place on a stack with room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !full)
    else $error("push on full stack");

  // A pending result only moves on when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwritten in output register");

endmodule

>>> sv/plts_ctrl.sv
module plts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output plts_pkg::dp_cmd_t cmd,
  input  plts_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GAP,
    ST_LOAD,
    ST_FLUSH,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Retire or preempt the running task.
        if (!sts.run_valid) begin
          state_nxt = ST_LOAD;
        end else if (sts.ended) begin
          if (sts.emit_ok) begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = plts_pkg::SRC_RUN;
            cmd.store_gap = 1'b1;
            state_nxt     = ST_GAP;
          end
        end else if (!sts.full) begin
          cmd.push  = 1'b1;
          state_nxt = ST_LOAD;
        end else if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = plts_pkg::SRC_RUN;
          cmd.emit_ovf = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      ST_GAP: begin
        // Spend idle time on stacked tasks, newest first.
        if (sts.gap_zero || sts.empty) begin
          state_nxt = ST_LOAD;
        end else if (!sts.top_fits) begin
          cmd.trim  = 1'b1;
          state_nxt = ST_LOAD;
        end else if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = plts_pkg::SRC_TOP;
          cmd.pop      = 1'b1;
        end
      end
      ST_LOAD: begin
        // The new task starts; a last task completes at once.
        if (!sts.last) begin
          cmd.load_run = 1'b1;
          state_nxt    = ST_FIN;
        end else if (sts.emit_ok) begin
          cmd.load_run = 1'b1;
          cmd.emit     = 1'b1;
          cmd.emit_src = plts_pkg::SRC_IN;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Empty the whole stack.
        if (sts.empty) begin
          state_nxt = ST_FIN;
        end else if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = plts_pkg::SRC_TOP;
          cmd.pop      = 1'b1;
        end
      end
      ST_FIN: begin
        // Hand over the final result of this word, marked as such.
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  // No result of a finished word is left behind in the pending stage.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !sts.pend_valid)
    else $error("pending result left at idle");

endmodule

>>> sv/preemptive_lifo_task_scheduler.sv
// Preemptive LIFO task scheduler. Feed tasks in nondecreasing start order on in_task;
// each new task preempts a running one that has not ended, which goes onto a stack of
// STACK_DEPTH entries with its remaining time, or is reported with overflow set when the
// stack is full. Completed tasks come out on out_done in completion order, and last_of_run
// marks the final word caused by each input word. A word with last_task set flushes the
// running task and the whole stack. A task word is taken in idle, checked against the
// running task, then spends idle time on stacked entries when that task has ended, loads
// the new task, flushes the stack for a last word and hands over its final result. Pops
// take one entry per cycle from the stack memory while out_done accepts results.
module preemptive_lifo_task_scheduler #(
  parameter int STACK_DEPTH = plts_pkg::STACK_DEPTH_DEF,
  parameter int ID_BITS     = plts_pkg::ID_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  plts_task_if.sink   in_task,
  plts_done_if.source out_done
);

  plts_pkg::dp_cmd_t cmd;
  plts_pkg::dp_sts_t sts;
  logic              in_ready;

  // Sequencing of one task word.
  plts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_task.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Running task, stack and result registers.
  plts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_id     (in_task.task_id),
    .in_start  (in_task.start_minute),
    .in_dur    (in_task.duration),
    .in_last   (in_task.last_task),
    .out_valid (out_done.valid),
    .out_ready (out_done.ready),
    .out_id    (out_done.done_id),
    .out_ovf   (out_done.overflow),
    .out_last  (out_done.last_of_run)
  );

  assign in_task.ready = in_ready;

endmodule
